>>> rtl/core/fbal_pkg.sv
`default_nettype none
package fbal_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int MEMORY_WORDS  = 65536;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int ADDR_W        = 16;
	localparam int SIZE_W        = 17;

	// best fit only considers blocks below this bound
	localparam logic [SIZE_W-1:0] BEST_INIT = SIZE_W'(MEMORY_WORDS + 1);

	// action codes
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_ALLOC  = 2'd2;

	// placement policy codes; anything else behaves as first fit
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2
	} status_code_t;

	// table read address source
	typedef enum logic [1:0] {
		RD_ZERO,
		RD_SCAN_NEXT,
		RD_PICK_NEXT,
		RD_SHIFT_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic         load;
		logic         clr;
		logic         append;
		logic         scan_init;
		logic         scan_step;
		logic         shrink;
		logic         shift_init;
		logic         shift_step;
		logic         dec;
		logic         emit;
		logic         grant;
		status_code_t code;
		rd_sel_t      rd_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic table_full;
		logic count_zero;
		logic hit;
		logic scan_last;
		logic found;
		logic exact;
		logic shift_more;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/fbal_datapath.sv
`default_nettype none
module fbal_datapath
	import fbal_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [ADDR_W-1:0] block_address,
	input  wire logic [SIZE_W-1:0] block_size,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_wdata,
	input  wire dp_cmd_t           cmd,
	output dp_stat_t               stat,
	output logic                   done,
	output logic [ADDR_W-1:0]      granted_address,
	output logic [1:0]             status,
	output logic [CNT_W-1:0]       free_entries
);

	// free block table
	logic [ADDR_W-1:0] start_mem [TABLE_ENTRIES];
	logic [SIZE_W-1:0] len_mem   [TABLE_ENTRIES];

	logic [1:0]        policy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [IDX_W-1:0]  sh_idx_q;
	logic [IDX_W-1:0]  pick_idx_q;
	logic [ADDR_W-1:0] pick_start_q;
	logic [SIZE_W-1:0] pick_len_q;
	logic              found_q;
	logic [SIZE_W-1:0] best_q;
	logic [SIZE_W-1:0] worst_q;
	logic [ADDR_W-1:0] rd_start_q;
	logic [SIZE_W-1:0] rd_len_q;
	logic              done_q;
	logic [ADDR_W-1:0] grant_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  free_q;

	logic [IDX_W-1:0]  rd_idx;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [ADDR_W-1:0] wr_start;
	logic [SIZE_W-1:0] wr_len;
	logic              fits;
	logic              cand;
	logic              pol_first;

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	// read address select
	always_comb begin
		unique case (cmd.rd_sel)
			RD_SCAN_NEXT:  rd_idx = scan_idx_q + IDX_W'(1);
			RD_PICK_NEXT:  rd_idx = pick_idx_q + IDX_W'(1);
			RD_SHIFT_NEXT: rd_idx = sh_idx_q + IDX_W'(2);
			default:       rd_idx = '0;
		endcase
	end

	// write port select
	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = cnt_q[IDX_W-1:0];
		wr_start = block_address;
		wr_len   = block_size;
		priority if (cmd.append) begin
			wr_en = 1'b1;
		end else if (cmd.shrink) begin
			wr_en    = 1'b1;
			wr_idx   = pick_idx_q;
			wr_start = pick_start_q + size_q[ADDR_W-1:0];
			wr_len   = pick_len_q - size_q;
		end else if (cmd.shift_step) begin
			wr_en    = 1'b1;
			wr_idx   = sh_idx_q;
			wr_start = rd_start_q;
			wr_len   = rd_len_q;
		end
	end

	// table storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_idx] <= wr_start;
			len_mem[wr_idx]   <= wr_len;
		end
		rd_start_q <= start_mem[rd_idx];
		rd_len_q   <= len_mem[rd_idx];
	end

	// candidate test on the entry just read
	assign pol_first = (policy_q != POL_BEST) && (policy_q != POL_WORST);
	assign fits      = rd_len_q >= size_q;
	always_comb begin
		unique case (policy_q)
			POL_BEST:  cand = fits && (rd_len_q < best_q);
			POL_WORST: cand = fits && (rd_len_q > worst_q);
			default:   cand = fits;
		endcase
	end

	// next entry count
	always_comb begin
		cnt_d = cnt_q;
		priority if (cmd.clr) begin
			cnt_d = '0;
		end else if (cmd.append) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (cmd.dec) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			done_q <= cmd.emit;
			if (cmd.scan_init) begin
				found_q <= 1'b0;
			end else if (cmd.scan_step && cand) begin
				found_q <= 1'b1;
			end
		end
	end

	// request, scan and shift registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q <= block_size;
		end
		if (cmd.scan_init) begin
			scan_idx_q <= '0;
			best_q     <= BEST_INIT;
			worst_q    <= '0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (cand) begin
				pick_idx_q   <= scan_idx_q;
				pick_start_q <= rd_start_q;
				pick_len_q   <= rd_len_q;
				best_q       <= rd_len_q;
				worst_q      <= rd_len_q;
			end
		end
		if (cmd.shift_init) begin
			sh_idx_q <= pick_idx_q;
		end else if (cmd.shift_step) begin
			sh_idx_q <= sh_idx_q + IDX_W'(1);
		end
		if (cmd.emit) begin
			grant_q  <= cmd.grant ? pick_start_q : '0;
			status_q <= cmd.code;
			free_q   <= cnt_d;
		end
	end

	// status to the controller
	assign stat.table_full = cnt_q == CNT_W'(TABLE_ENTRIES);
	assign stat.count_zero = cnt_q == '0;
	assign stat.hit        = fits && pol_first;
	assign stat.scan_last  = (CNT_W'(scan_idx_q) + CNT_W'(1)) == cnt_q;
	assign stat.found      = found_q;
	assign stat.exact      = pick_len_q == size_q;
	assign stat.shift_more = (CNT_W'(sh_idx_q) + CNT_W'(1)) < cnt_q;

	assign done            = done_q;
	assign granted_address = grant_q;
	assign status          = status_q;
	assign free_entries    = free_q;

endmodule
`default_nettype wire

>>> rtl/core/fbal_ctrl.sv
`default_nettype none
module fbal_ctrl
	import fbal_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic [1:0] action,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT
	} state_t;

	state_t state_q;
	state_t state_d;

	// commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (action)
						ACT_CLEAR: begin
							cmd.clr  = 1'b1;
							cmd.emit = 1'b1;
						end
						ACT_APPEND: begin
							cmd.emit = 1'b1;
							if (stat.table_full) begin
								cmd.code = ST_FULL;
							end else begin
								cmd.append = 1'b1;
							end
						end
						ACT_ALLOC: begin
							if (stat.count_zero) begin
								cmd.emit = 1'b1;
								cmd.code = ST_NOFIT;
							end else begin
								cmd.scan_init = 1'b1;
								state_d       = S_SCAN;
							end
						end
						default: begin
							cmd.emit = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				// evaluate entry in hand, fetch the following one
				cmd.scan_step = 1'b1;
				cmd.rd_sel    = RD_SCAN_NEXT;
				if (stat.hit || stat.scan_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.found) begin
					cmd.emit = 1'b1;
					cmd.code = ST_NOFIT;
					state_d  = S_IDLE;
				end else if (!stat.exact) begin
					cmd.shrink = 1'b1;
					cmd.emit   = 1'b1;
					cmd.grant  = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.shift_init = 1'b1;
					cmd.rd_sel     = RD_PICK_NEXT;
					state_d        = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (stat.shift_more) begin
					cmd.shift_step = 1'b1;
					cmd.rd_sel     = RD_SHIFT_NEXT;
				end else begin
					cmd.dec   = 1'b1;
					cmd.emit  = 1'b1;
					cmd.grant = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule
`default_nettype wire

>>> rtl/core/fit_policy_free_block_allocator.sv
`default_nettype none
// Free block allocator over a 16-entry ordered table of (address, size) blocks.
// A request is taken when start is high and busy is low; its result appears
// on granted_address, status and free_entries for exactly one cycle with done
// high, and must be captured then, since the result side cannot stall.
// Clear, append, unused actions and an allocate on an empty table are answered
// from idle with busy low. An allocate keeps busy high while it scans the held
// entries (first fit stops at the first block that fits; best fit, worst fit
// and a miss read all of them, one per cycle through the table's single read
// port) and, when the chosen entry is used up exactly, while later entries move
// up one place a cycle; done rises as busy falls. A new request may be started
// while done is high. The user must write fit_policy through cfg_we / cfg_wdata
// only while no request is open; the block itself does not enforce this.
module fit_policy_free_block_allocator
	import fbal_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        action,
	input  wire logic [ADDR_W-1:0] block_address,
	input  wire logic [SIZE_W-1:0] block_size,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_wdata,
	output logic                   done,
	output logic [ADDR_W-1:0]      granted_address,
	output logic [1:0]             status,
	output logic [CNT_W-1:0]       free_entries
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fbal_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	fbal_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.block_address   (block_address),
		.block_size      (block_size),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd),
		.stat            (stat),
		.done            (done),
		.granted_address (granted_address),
		.status          (status),
		.free_entries    (free_entries)
	);

endmodule
`default_nettype wire

>>> tb/tb_fit_policy_free_block_allocator.sv
`timescale 1ns / 100ps

module tb_fit_policy_free_block_allocator;
	import fbal_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] POL_UNUSED = 2'd3;

	// slowest allocate: full scan plus a full shift, with margin
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [ADDR_W-1:0] grant;
		status_code_t      st;
		logic [CNT_W-1:0]  count;
	} alloc_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        action = ACT_CLEAR;
	logic [ADDR_W-1:0] block_address = '0;
	logic [SIZE_W-1:0] block_size = '0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_wdata = POL_FIRST;
	logic              done;
	logic [ADDR_W-1:0] granted_address;
	logic [1:0]        status;
	logic [CNT_W-1:0]  free_entries;

	// shadow copy of the free table and the policy register
	logic [ADDR_W-1:0] tbl_addr [TABLE_ENTRIES];
	logic [SIZE_W-1:0] tbl_size [TABLE_ENTRIES];
	int                tbl_count = 0;
	logic [1:0]        policy_setting = POL_FIRST;

	alloc_result_t pending_results [$];
	int            mismatches = 0;
	bit            steady_sender = 1'b0;

	fit_policy_free_block_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.block_address   (block_address),
		.block_size      (block_size),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.granted_address (granted_address),
		.status          (status),
		.free_entries    (free_entries)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endfunction

	// apply one accepted request to the shadow table and return its result
	function automatic alloc_result_t predict_result(input logic [1:0] act,
			input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size);
		alloc_result_t r;
		int pick;
		int best;
		int worst;
		int margin;
		int i;
		r.grant = '0;
		r.st = ST_OK;
		case (act)
			ACT_CLEAR: begin
				tbl_count = 0;
			end
			ACT_APPEND: begin
				if (tbl_count >= TABLE_ENTRIES) begin
					r.st = ST_FULL;
				end else begin
					tbl_addr[tbl_count] = addr;
					tbl_size[tbl_count] = size;
					tbl_count++;
				end
			end
			ACT_ALLOC: begin
				pick = tbl_count;
				best = MEMORY_WORDS + 1;
				worst = 0;
				for (i = 0; i < tbl_count; i++) begin
					if (int'(tbl_size[i]) < int'(size)) continue;
					if (policy_setting == POL_BEST) begin
						if (int'(tbl_size[i]) < best) begin
							best = int'(tbl_size[i]);
							pick = i;
						end
					end else if (policy_setting == POL_WORST) begin
						if (int'(tbl_size[i]) > worst) begin
							worst = int'(tbl_size[i]);
							pick = i;
						end
					end else begin
						pick = i;
						break;
					end
				end
				if (pick == tbl_count) begin
					r.st = ST_NOFIT;
				end else begin
					r.grant = tbl_addr[pick];
					margin = int'(tbl_size[pick]) - int'(size);
					if (margin > 0) begin
						// shrink from the low end; address wraps at 16 bits
						tbl_addr[pick] = tbl_addr[pick] + size[ADDR_W-1:0];
						tbl_size[pick] = SIZE_W'(margin);
					end else begin
						for (i = pick; i + 1 < tbl_count; i++) begin
							tbl_addr[i] = tbl_addr[i + 1];
							tbl_size[i] = tbl_size[i + 1];
						end
						tbl_count--;
					end
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(tbl_count);
		return r;
	endfunction

	// send one request; start is left high, settle() or a random gap drops it
	task automatic issue_request(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
			input logic [SIZE_W-1:0] size);
		if (!steady_sender && $urandom_range(99) < 33) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		action <= act;
		block_address <= addr;
		block_size <= size;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_result(act, addr, size));
	endtask

	// drop start and wait until every result is back
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_policy(input logic [1:0] pol);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= pol;
		@(negedge clk);
		cfg_we <= 1'b0;
		policy_setting = pol;
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: addr=%h status=%0d entries=%0d",
					granted_address, status, free_entries));
			end else begin
				want = pending_results.pop_front();
				if (granted_address !== want.grant || status !== want.st ||
						free_entries !== want.count) begin
					flag_mismatch($sformatf(
						"exp addr=%h status=%0d entries=%0d, got addr=%h status=%0d entries=%0d",
						want.grant, want.st, want.count, granted_address, status,
						free_entries));
				end
			end
		end
	end

	// empty table, unused action code, clear
	task automatic test_empty_and_unused();
		issue_request(ACT_ALLOC, 16'h0000, 17'd5);
		issue_request(ACT_UNUSED, 16'hFFFF, 17'h1FFFF);
		issue_request(ACT_CLEAR, 16'hFFFF, 17'h1FFFF);
	endtask

	// first fit: zero-size request, grant at address zero, wrap on shrink, exact use
	task automatic test_first_fit_edges();
		write_policy(POL_FIRST);
		issue_request(ACT_APPEND, 16'h0000, 17'd0);
		issue_request(ACT_APPEND, 16'hFFFF, 17'd5);
		issue_request(ACT_APPEND, 16'h1234, 17'h1FFFF);
		issue_request(ACT_ALLOC, 16'h0000, 17'd0);
		issue_request(ACT_ALLOC, 16'h0000, 17'd2);
		issue_request(ACT_ALLOC, 16'h0000, 17'd3);
		issue_request(ACT_ALLOC, 16'h0000, 17'd65536);
	endtask

	// ties under best and worst fit go to the first candidate
	task automatic test_policy_ties();
		issue_request(ACT_CLEAR, 16'h0000, 17'd0);
		issue_request(ACT_APPEND, 16'h0100, 17'd8);
		issue_request(ACT_APPEND, 16'h0200, 17'd4);
		issue_request(ACT_APPEND, 16'h0300, 17'd8);
		issue_request(ACT_APPEND, 16'h0400, 17'd4);
		write_policy(POL_BEST);
		issue_request(ACT_ALLOC, 16'h0000, 17'd4);
		write_policy(POL_WORST);
		issue_request(ACT_ALLOC, 16'h0000, 17'd3);
	endtask

	// full table, dropped append, best fit size bound, full scans
	task automatic test_full_table();
		int i;
		issue_request(ACT_CLEAR, 16'h0000, 17'd0);
		issue_request(ACT_APPEND, 16'h8000, 17'h1FFFF);
		for (i = 1; i < TABLE_ENTRIES; i++) begin
			issue_request(ACT_APPEND, ADDR_W'($urandom), SIZE_W'($urandom_range(64, 1)));
		end
		issue_request(ACT_APPEND, 16'h5555, 17'd7);
		write_policy(POL_BEST);
		issue_request(ACT_ALLOC, 16'h0000, 17'd70000);
		issue_request(ACT_ALLOC, 16'h0000, 17'd1);
		write_policy(POL_WORST);
		issue_request(ACT_ALLOC, 16'h0000, 17'd70000);
		write_policy(POL_UNUSED);
		issue_request(ACT_ALLOC, 16'h0000, 17'd1);
	endtask

	// random mix, biased toward sizes that hit or exactly use up held blocks
	task automatic test_random_traffic(input logic [1:0] pol, input int n_items,
			input bit steady);
		int n;
		int r;
		logic [1:0] act;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		write_policy(pol);
		steady_sender = steady;
		for (n = 0; n < n_items; n++) begin
			r = $urandom_range(99);
			if (r < 4) act = ACT_CLEAR;
			else if (r < 7) act = ACT_UNUSED;
			else if (r < 52) act = ACT_APPEND;
			else act = ACT_ALLOC;
			if (act == ACT_APPEND && tbl_count == TABLE_ENTRIES && $urandom_range(3) != 0)
				act = ACT_ALLOC;
			addr = ($urandom_range(4) == 0) ? ADDR_W'($urandom_range(16'hFFFF, 16'hFFF0))
				: ADDR_W'($urandom);
			r = $urandom_range(99);
			if (act == ACT_ALLOC) begin
				if (tbl_count > 0 && r < 35) size = tbl_size[$urandom_range(tbl_count - 1)];
				else if (r < 75) size = SIZE_W'($urandom_range(16, 1));
				else if (r < 85) size = SIZE_W'($urandom_range(255));
				else if (r < 90) size = '0;
				else size = SIZE_W'($urandom);
			end else begin
				if (r < 65) size = SIZE_W'($urandom_range(16, 1));
				else if (r < 80) size = SIZE_W'($urandom_range(1023));
				else if (r < 90) size = SIZE_W'($urandom);
				else begin
					case ($urandom_range(5))
						0: size = '0;
						1: size = 17'd1;
						2: size = 17'd65535;
						3: size = 17'd65536;
						4: size = 17'd65537;
						default: size = 17'h1FFFF;
					endcase
				end
			end
			issue_request(act, addr, size);
		end
		steady_sender = 1'b0;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_and_unused();
		test_first_fit_edges();
		test_policy_ties();
		test_full_table();
		test_random_traffic(POL_BEST, 450, 1'b1);
		test_random_traffic(POL_WORST, 450, 1'b0);
		test_random_traffic(POL_UNUSED, 450, 1'b0);
		test_random_traffic(POL_FIRST, 450, 1'b0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/fbal_pkg.sv
rtl/core/fbal_datapath.sv
rtl/core/fbal_ctrl.sv
rtl/core/fit_policy_free_block_allocator.sv
tb/tb_fit_policy_free_block_allocator.sv
